### sv/pes_pkg.sv
// Package for the polygon edge span table: sizes, request codes and beat types.
// Used by every module in sv/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pes_pkg;

    // Table geometry and fixed-point format
    localparam int unsigned ROWS          = 1024;
    localparam int unsigned FRACTION_BITS = 16;
    localparam int unsigned ADDR_W        = $clog2(ROWS);

    // Field widths fixed by the interface
    localparam int unsigned COORD_W = 10;
    localparam int unsigned LEFT_W  = COORD_W + 1;
    localparam int unsigned TYPE_W  = 2;

    // Column position and divider sizes
    localparam int unsigned POS_W     = COORD_W + FRACTION_BITS;
    localparam int unsigned DIV_CNT_W = $clog2(POS_W + 1);

    // Table word: left bound over right bound
    localparam int unsigned WORD_W = LEFT_W + COORD_W;

    // Left bound of an empty row
    localparam logic [LEFT_W-1:0] EMPTY_LEFT = LEFT_W'(1024);

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_EDGE  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } pes_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] span_row;
        logic [LEFT_W-1:0]  span_left;
        logic [COORD_W-1:0] span_right;
        logic               span_nonempty;
    } pes_rsp_t;

endpackage

`default_nettype wire

### sv/polygon_edge_span_table_core.sv
// Top level of the polygon edge span table: sequencer, row table memory, output stage.
// Depends on pes_pkg and pes_div.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a left and right column bound for each of ROWS rows in one
// single-port-write, single-port-read table memory, and takes one request at a
// time. After reset, and after every clear request, a clearing pass writes one
// row per cycle through all ROWS rows (1024 by default), with req_ready low.
// An edge request whose two rows are equal is taken and leaves the table as it
// is; otherwise the bit-serial divider first works out the column step, and then
// each spanned row takes a table read, then a compare and write. A query steps
// through address, registered table read and output load, and its response waits
// in an output register, so the next request is taken while rsp_valid is still
// high; a query taken while that register is full holds in its last step until
// the register drains.
// An unused request code is taken and dropped.
module polygon_edge_span_table_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire pes_pkg::pes_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output pes_pkg::pes_rsp_t      rsp
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_ERD,
        S_EWR,
        S_QRD,
        S_QOUT
    } state_t;

    state_t                        state_reg;
    logic [pes_pkg::ADDR_W-1:0]    clr_cnt_reg;
    logic [pes_pkg::ADDR_W-1:0]    addr_reg;
    logic [pes_pkg::COORD_W-1:0]   row_reg;
    logic [pes_pkg::COORD_W-1:0]   end_row_reg;
    logic [pes_pkg::COORD_W-1:0]   xa_reg;
    logic                          down_reg;
    logic [pes_pkg::POS_W-1:0]     pos_reg;
    logic [pes_pkg::POS_W-1:0]     step_reg;
    logic                          rsp_valid_reg;
    pes_pkg::pes_rsp_t             rsp_reg;

    // Table memory
    logic [pes_pkg::WORD_W-1:0]    mem [pes_pkg::ROWS];
    logic [pes_pkg::WORD_W-1:0]    rd_q;
    logic                          wr_en;
    logic [pes_pkg::ADDR_W-1:0]    wr_addr;
    logic [pes_pkg::WORD_W-1:0]    wr_data;

    // Request decode
    logic                          accept;
    logic                          swap;
    logic [pes_pkg::COORD_W-1:0]   xa, xb, ya, yb;
    logic [pes_pkg::COORD_W-1:0]   dy, mag;
    logic                          flat;
    logic                          div_start;
    logic                          div_done;
    logic [pes_pkg::POS_W-1:0]     div_quo;

    // Row update
    logic [pes_pkg::COORD_W-1:0]   col;
    logic [pes_pkg::LEFT_W-1:0]    cur_left;
    logic [pes_pkg::COORD_W-1:0]   cur_right;
    logic [pes_pkg::LEFT_W-1:0]    new_left;
    logic [pes_pkg::COORD_W-1:0]   new_right;
    logic                          row_in_table;
    logic [pes_pkg::COORD_W-1:0]   row_inc;
    logic [pes_pkg::POS_W-1:0]     pos_step;
    logic                          q_in_table;
    logic [pes_pkg::LEFT_W-1:0]    q_left;
    logic [pes_pkg::COORD_W-1:0]   q_right;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    // Order endpoints by row and size the step division
    always_comb
    begin
        swap      = (req.end_y < req.start_y);
        xa        = swap ? req.end_x   : req.start_x;
        ya        = swap ? req.end_y   : req.start_y;
        xb        = swap ? req.start_x : req.end_x;
        yb        = swap ? req.start_y : req.end_y;
        flat      = (ya == yb);
        dy        = yb - ya;
        mag       = (xb < xa) ? (xa - xb) : (xb - xa);
        div_start = accept && (req.req_type == pes_pkg::REQ_EDGE) && !flat;
    end

    pes_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({mag, {pes_pkg::FRACTION_BITS{1'b0}}}),
        .divisor  (dy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Lower the left bound and raise the right bound with the current column
    always_comb
    begin
        col          = pos_reg[pes_pkg::POS_W-1:pes_pkg::FRACTION_BITS];
        cur_left     = rd_q[pes_pkg::WORD_W-1:pes_pkg::COORD_W];
        cur_right    = rd_q[pes_pkg::COORD_W-1:0];
        new_left     = ({1'b0, col} < cur_left) ? {1'b0, col} : cur_left;
        new_right    = (col > cur_right) ? col : cur_right;
        row_in_table = (32'(row_reg) < pes_pkg::ROWS);
        row_inc      = row_reg + 1'b1;
        if (down_reg)
        begin
            pos_step = (pos_reg >= step_reg) ? (pos_reg - step_reg) : '0;
        end
        else
        begin
            pos_step = pos_reg + step_reg;
        end
    end

    // Query result: rows beyond the table read as empty
    always_comb
    begin
        q_in_table = (32'(row_reg) < pes_pkg::ROWS);
        q_left     = q_in_table ? rd_q[pes_pkg::WORD_W-1:pes_pkg::COORD_W]
                                : pes_pkg::EMPTY_LEFT;
        q_right    = q_in_table ? rd_q[pes_pkg::COORD_W-1:0] : '0;
    end

    // Table write port: clearing pass or row update
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = {new_left, new_right};
        case (state_reg)
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = {pes_pkg::EMPTY_LEFT, {pes_pkg::COORD_W{1'b0}}};
            end
            S_EWR:
            begin
                wr_en = row_in_table;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[addr_reg];
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid when a query loads its beat, drop it once taken
            if (state_reg == S_QOUT && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    if (clr_cnt_reg == pes_pkg::ADDR_W'(pes_pkg::ROWS - 1))
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.req_type)
                            pes_pkg::REQ_EDGE:
                            begin
                                if (!flat)
                                begin
                                    state_reg <= S_DIV;
                                end
                            end
                            pes_pkg::REQ_QUERY:
                            begin
                                state_reg <= S_QRD;
                            end
                            pes_pkg::REQ_CLEAR:
                            begin
                                state_reg <= S_CLR;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_ERD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EWR;
                end
                S_EWR:
                begin
                    state_reg <= (row_inc == end_row_reg) ? S_IDLE : S_ERD;
                end
                S_QRD:
                begin
                    state_reg <= S_QOUT;
                end
                S_QOUT:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    xa_reg      <= xa;
                    end_row_reg <= yb;
                    down_reg    <= (xb < xa);
                    row_reg     <= (req.req_type == pes_pkg::REQ_QUERY) ? req.start_y : ya;
                    addr_reg    <= pes_pkg::ADDR_W'((req.req_type == pes_pkg::REQ_QUERY)
                                                    ? req.start_y : ya);
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    step_reg <= div_quo;
                    pos_reg  <= {xa_reg, {pes_pkg::FRACTION_BITS{1'b0}}};
                end
            end
            S_EWR:
            begin
                pos_reg  <= pos_step;
                row_reg  <= row_inc;
                addr_reg <= pes_pkg::ADDR_W'(row_inc);
            end
            S_QOUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_reg.span_row      <= row_reg;
                    rsp_reg.span_left     <= q_left;
                    rsp_reg.span_right    <= q_right;
                    rsp_reg.span_nonempty <= (q_left < {1'b0, q_right});
                end
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

### sv/pes_div.sv
// Restoring divider, one quotient bit per cycle, for the edge column step.
// Depends on pes_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module pes_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [pes_pkg::POS_W-1:0]    dividend,
    input  wire logic [pes_pkg::COORD_W-1:0]  divisor,
    output logic                              done,
    output logic [pes_pkg::POS_W-1:0]         quotient
);

    logic [pes_pkg::COORD_W-1:0]   rem_reg;
    logic [pes_pkg::POS_W-1:0]     quo_reg;
    logic [pes_pkg::COORD_W-1:0]   dsr_reg;
    logic [pes_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;

    logic [pes_pkg::COORD_W:0]     trial;
    logic                          fits;
    logic [pes_pkg::COORD_W:0]     diff;

    // Shift the next dividend bit into the partial remainder and try to subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[pes_pkg::POS_W-1]};
        fits  = (trial >= {1'b0, dsr_reg});
        diff  = trial - {1'b0, dsr_reg};
    end

    // Control: count quotient bits, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= pes_pkg::DIV_CNT_W'(pes_pkg::POS_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pes_pkg::DIV_CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[pes_pkg::COORD_W-1:0] : trial[pes_pkg::COORD_W-1:0];
            quo_reg <= {quo_reg[pes_pkg::POS_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### sv/pes_chk.sv
// Port-level checker for polygon_edge_span_table_core, bound to the top level.
// Depends on pes_pkg for the beat types and request codes.
`timescale 1ns / 1ps
`default_nettype none

module pes_chk (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_ready,
    input  wire pes_pkg::pes_req_t req,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_ready,
    input  wire pes_pkg::pes_rsp_t rsp
);

    // Hold a stalled response beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // Nonempty flag agrees with the reported bounds
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.span_nonempty == (rsp.span_left < {1'b0, rsp.span_right})))
        else $error("span_nonempty disagrees with bounds");

    // Left bound never passes the empty marker
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.span_left <= pes_pkg::EMPTY_LEFT))
        else $error("span_left out of range");

    // A query or clear keeps the block busy in the following cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready &&
        (req.req_type == pes_pkg::REQ_QUERY || req.req_type == pes_pkg::REQ_CLEAR)
        |=> !req_ready)
        else $error("request accepted while a query or clear is in flight");

endmodule

bind polygon_edge_span_table_core pes_chk u_pes_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
